// ===== rtl/hwle_pkg.sv =====
// shared types and codes for the hex word list to little-endian byte converter
// no dependencies; used by the channel interfaces and all rtl modules
package hwle_pkg;

   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned ACC_W      = 64;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned NBYTES_W   = 4;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_ODD      = 2'd1;
   localparam status_type STATUS_WIDTH    = 2'd2;
   localparam status_type STATUS_MISMATCH = 2'd3;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // everything one character produces for the output side
   typedef struct packed {
      logic [ACC_W-1:0]    group;
      logic [NBYTES_W-1:0] nbytes;
      logic                end_flag;
      status_type          status;
   } burst_type;

endpackage

// ===== rtl/hwle_req_if.sv =====
// character channel: valid/ready handshake with one text character as payload
// depends on hwle_pkg
interface hwle_req_if;
   logic                          valid;
   logic                          ready;
   logic [hwle_pkg::CHAR_W-1:0]   char_code;
   logic                          end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== rtl/hwle_rsp_if.sv =====
// result channel: valid/ready handshake carrying data bytes and end status
// depends on hwle_pkg
interface hwle_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [hwle_pkg::BYTE_W-1:0]   data_byte;
   logic [hwle_pkg::STATUS_W-1:0] status_code;
   logic                          last_of_run;

   modport source (output valid, output kind, output data_byte, output status_code,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input data_byte, input status_code,
                   input last_of_run, output ready);
endinterface

// ===== rtl/hwle_emit.sv =====
// output burst register: holds one group plus an optional end result and
// drains it one transfer per cycle when ready; uses hwle_pkg and hwle_rsp_if
module hwle_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_en,
   input  hwle_pkg::burst_type load,
   output logic                free,
   hwle_rsp_if.source          rsp_chan
);
   import hwle_pkg::*;

   logic [ACC_W-1:0]    data_ff,  data_in;
   logic [NBYTES_W-1:0] left_ff,  left_in;
   logic                end_ff,   end_in;
   status_type          status_ff, status_in;

   logic bytes_pending;
   logic final_result;
   logic take;

   assign bytes_pending = (left_ff != '0);
   assign final_result  = (bytes_pending && left_ff == NBYTES_W'(1) && !end_ff) ||
                          !bytes_pending;
   assign take          = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.valid       = bytes_pending || end_ff;
   assign rsp_chan.kind        = bytes_pending ? KIND_DATA : KIND_END;
   assign rsp_chan.data_byte   = bytes_pending ? data_ff[BYTE_W-1:0] : '0;
   assign rsp_chan.status_code = bytes_pending ? STATUS_OK : status_ff;
   assign rsp_chan.last_of_run = final_result;

   // free now, or the final result leaves in this cycle
   assign free = !rsp_chan.valid || (take && final_result);

   always_comb begin
      data_in   = data_ff;
      left_in   = left_ff;
      end_in    = end_ff;
      status_in = status_ff;
      if (load_en) begin
         data_in   = load.group;
         left_in   = load.nbytes;
         end_in    = load.end_flag;
         status_in = load.status;
      end else if (take) begin
         if (bytes_pending) begin
            data_in = data_ff >> BYTE_W;
            left_in = left_ff - NBYTES_W'(1);
         end else begin
            end_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      status_ff <= status_in;
      if (reset) begin
         left_ff <= '0;
         end_ff  <= 1'b0;
      end else begin
         left_ff <= left_in;
         end_ff  <= end_in;
      end
   end

endmodule

// ===== rtl/hex_word_list_to_le_bytes.sv =====
// hex word list to little-endian bytes, top level
// latency: results of a character appear the cycle after its transfer
// throughput: one character per cycle while each character causes at most one
//   result and the sink is ready; a character that closes a group holds the input
//   until its results are out (the output burst register drains one byte per cycle)
// reset: synchronous, clears all parse state and drops any pending results
module hex_word_list_to_le_bytes (
   input  logic       clock,
   input  logic       reset,
   hwle_req_if.sink   req_chan,
   hwle_rsp_if.source rsp_chan
);
   import hwle_pkg::*;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_RUN   = 2'd1,
      PH_GAP   = 2'd2
   } phase_type;

   logic [ACC_W-1:0]   acc_ff,   acc_in;
   logic [COUNT_W-1:0] cnt_ff,   cnt_in;
   logic [COUNT_W-1:0] lock_ff,  lock_in;
   phase_type          phase_ff, phase_in;
   status_type         err_ff,   err_in;

   logic       is_hex;
   logic [3:0] nib;
   logic       do_close;
   logic       emit_free;
   logic       req_take;
   burst_type  burst;

   assign req_chan.ready = emit_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      is_hex = 1'b1;
      nib    = '0;
      if (req_chan.char_code >= "0" && req_chan.char_code <= "9") begin
         nib = 4'(req_chan.char_code - "0");
      end else if (req_chan.char_code >= "a" && req_chan.char_code <= "f") begin
         nib = 4'(req_chan.char_code - "a" + 8'd10);
      end else if (req_chan.char_code >= "A" && req_chan.char_code <= "F") begin
         nib = 4'(req_chan.char_code - "A" + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      lock_in      = lock_ff;
      phase_in     = phase_ff;
      err_in       = err_ff;
      do_close     = 1'b0;
      burst.nbytes = '0;

      if (err_ff == STATUS_OK) begin
         if (is_hex) begin
            if (phase_ff != PH_RUN) begin
               acc_in = '0;
               cnt_in = '0;
            end
            acc_in   = {acc_in[ACC_W-5:0], nib};
            // past 16 digits only the parity of the count is kept
            if (cnt_in < COUNT_W'(16))       cnt_in = cnt_in + COUNT_W'(1);
            else if (cnt_in == COUNT_W'(17)) cnt_in = COUNT_W'(18);
            else                             cnt_in = COUNT_W'(17);
            phase_in = PH_RUN;
         end else begin
            // a leading separator closes an empty group
            if (phase_ff == PH_START) cnt_in = '0;
            do_close = (phase_ff == PH_START) || (phase_ff == PH_RUN);
            phase_in = PH_GAP;
         end
         if (req_chan.end_of_text && phase_in == PH_RUN) begin
            do_close = 1'b1;
            phase_in = PH_GAP;
         end
      end

      if (do_close) begin
         if (lock_ff == '0) begin
            if (cnt_in[0]) begin
               err_in = STATUS_ODD;
            end else if (cnt_in != COUNT_W'(2) && cnt_in != COUNT_W'(4) &&
                         cnt_in != COUNT_W'(8) && cnt_in != COUNT_W'(16)) begin
               err_in = STATUS_WIDTH;
            end else begin
               lock_in      = cnt_in;
               burst.nbytes = cnt_in[COUNT_W-1:1];
            end
         end else if (cnt_in != lock_ff) begin
            err_in = STATUS_MISMATCH;
         end else begin
            burst.nbytes = cnt_in[COUNT_W-1:1];
         end
      end

      burst.group    = acc_in;
      burst.end_flag = req_chan.end_of_text;
      burst.status   = err_in;

      // end of string returns the parser to its reset state
      if (req_chan.end_of_text) begin
         acc_in   = '0;
         cnt_in   = '0;
         lock_in  = '0;
         phase_in = PH_START;
         err_in   = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         cnt_ff   <= '0;
         lock_ff  <= '0;
         phase_ff <= PH_START;
         err_ff   <= STATUS_OK;
      end else if (req_take) begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         lock_ff  <= lock_in;
         phase_ff <= phase_in;
         err_ff   <= err_in;
      end
   end

   hwle_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load_en  (req_take),
      .load     (burst),
      .free     (emit_free),
      .rsp_chan (rsp_chan)
   );

endmodule
